// ===== hdl/sle_pkg.sv =====
package sle_pkg;

  // Fixed field widths of the command and result beats
  localparam int CMD_W   = 3;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR      = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_INSERT     = 3'd5,
    CMD_ERASE      = 3'd6,
    CMD_FIND       = 3'd7
  } cmd_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;    // capture the incoming command beat
    logic exec;     // apply the command to the store and count
    logic resolve;  // encode the find result and load the output register
  } sle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a new result this cycle
  } sle_stat_t;

endpackage

// ===== hdl/sle_if.sv =====
// Command channel
interface sle_in_if;
  import sle_pkg::*;

  logic                   valid;
  logic                   ready;
  cmd_e_t                 command;
  logic [POS_W-1:0]       position;
  logic [VALUE_W-1:0]     value;

  modport source (output valid, output command, output position, output value, input ready);
  modport sink   (input valid, input command, input position, input value, output ready);
endinterface

// Result channel
interface sle_out_if;
  import sle_pkg::*;

  logic                   valid;
  logic                   ready;
  status_e_t              status;
  logic                   found;
  logic [INDEX_W-1:0]     match_index;
  logic [COUNT_W-1:0]     count;

  modport source (output valid, output status, output found, output match_index,
                  output count, input ready);
  modport sink   (input valid, input status, input found, input match_index,
                  input count, output ready);
endinterface

// ===== hdl/sle_ctrl.sv =====
module sle_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output sle_pkg::sle_cmd_t    ctl,
  input  sle_pkg::sle_stat_t   stat
);
  import sle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_EXEC    = 3'b010,
    S_RESOLVE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Handshake and datapath strobes
  assign in_ready    = (state_r == S_IDLE);
  assign ctl.latch   = in_valid && in_ready;
  assign ctl.exec    = (state_r == S_EXEC);
  assign ctl.resolve = (state_r == S_RESOLVE) && stat.out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.latch) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A captured command always goes to execute next
  a_latch_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.latch |=> state_r == S_EXEC)
    else $error("accepted beat did not move to execute");

  // A result waiting on a busy output register is not dropped
  a_resolve_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESOLVE) && !stat.out_free |=> state_r == S_RESOLVE)
    else $error("result left resolve while output register was busy");

endmodule

// ===== hdl/sle_datapath.sv =====
module sle_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sle_pkg::sle_cmd_t             ctl,
  output sle_pkg::sle_stat_t            stat,
  input  sle_pkg::cmd_e_t               in_command,
  input  logic [sle_pkg::POS_W-1:0]     in_position,
  input  logic [sle_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sle_pkg::status_e_t            out_status,
  output logic                          out_found,
  output logic [sle_pkg::INDEX_W-1:0]   out_match_index,
  output logic [sle_pkg::COUNT_W-1:0]   out_count
);
  import sle_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  // Captured command beat
  cmd_e_t                 cmd_r;
  logic [POS_W-1:0]       pos_r;
  logic [DATA_WIDTH-1:0]  word_r;

  // List state
  logic [DATA_WIDTH-1:0]  store_r [DEPTH];
  logic [CW-1:0]          count_r, count_nxt;

  // Execute results
  status_e_t              status_r, status_nxt;
  logic [DEPTH-1:0]       match_r, match_nxt;

  // Output register
  logic                   out_valid_r;
  status_e_t              out_status_r;
  logic                   out_found_r;
  logic [INDEX_W-1:0]     out_index_r;
  logic [COUNT_W-1:0]     out_count_r;

  logic [PW-1:0]          eff_pos;
  logic [PW-1:0]          count_ext;
  logic                   do_ins, do_rem;
  logic [IW-1:0]          first_idx;
  logic                   any_match;

  logic [DATA_WIDTH-1:0]  below_w [DEPTH];
  logic [DATA_WIDTH-1:0]  above_w [DEPTH];

  // Capture the beat; value is sign-extended or cut to the word width
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r  <= in_command;
      pos_r  <= in_position;
      word_r <= DATA_WIDTH'(signed'(in_value));
    end
  end

  // Effective position and command checks
  always_comb begin
    count_ext = PW'(count_r);
    case (cmd_r)
      CMD_PUSH_BACK:               eff_pos = count_ext;
      CMD_PUSH_FRONT, CMD_POP_FRONT: eff_pos = '0;
      CMD_POP_BACK:                eff_pos = count_ext - 1'b1;
      default:                     eff_pos = PW'(pos_r);
    endcase

    status_nxt = ST_OK;
    count_nxt  = count_r;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    if (cmd_r == CMD_CLEAR) begin
      count_nxt = '0;
    end else if (cmd_r inside {CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT}) begin
      // position check comes before the full check
      if (eff_pos > count_ext) begin
        status_nxt = ST_RANGE;
      end else if (count_r >= CW'(DEPTH)) begin
        status_nxt = ST_FULL;
      end else begin
        do_ins    = 1'b1;
        count_nxt = CW'(count_r + 1'b1);
      end
    end else if (cmd_r inside {CMD_POP_BACK, CMD_POP_FRONT, CMD_ERASE}) begin
      if (count_r == '0) begin
        status_nxt = ST_EMPTY;
      end else if (eff_pos >= count_ext) begin
        status_nxt = ST_RANGE;
      end else begin
        do_rem    = 1'b1;
        count_nxt = CW'(count_r - 1'b1);
      end
    end
  end

  // One cell per entry: shift up, load, shift down, compare
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign below_w[k] = word_r;
    end else begin : g_below
      assign below_w[k] = store_r[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign above_w[k] = store_r[k];
    end else begin : g_above
      assign above_w[k] = store_r[k+1];
    end

    assign match_nxt[k] = (CW'(k) < count_r) && (store_r[k] == word_r);

    always_ff @(posedge clk) begin
      if (ctl.exec) begin
        if (do_ins && (PW'(k) > eff_pos)) begin
          store_r[k] <= below_w[k];
        end else if (do_ins && (PW'(k) == eff_pos)) begin
          store_r[k] <= word_r;
        end else if (do_rem && (PW'(k) >= eff_pos)) begin
          store_r[k] <= above_w[k];
        end
      end
    end
  end

  // Count and execute results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status_r <= status_nxt;
      match_r  <= (cmd_r == CMD_FIND) ? match_nxt : '0;
    end
  end

  // First match, lowest index wins
  always_comb begin
    first_idx = '0;
    any_match = |match_r;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) first_idx = IW'(i);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.resolve) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.resolve) begin
      out_status_r <= status_r;
      out_found_r  <= any_match;
      out_index_r  <= INDEX_W'(first_idx);
      out_count_r  <= COUNT_W'(count_r);
    end
  end

  assign stat.out_free    = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found        = out_found_r;
  assign out_match_index  = out_index_r;
  assign out_count        = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec && do_ins |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("successful insert did not grow the count");

  a_resolve_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.resolve |=> out_valid_r)
    else $error("resolved result not presented");

endmodule

// ===== hdl/sequential_list_engine.sv =====
// Ordered list of up to DEPTH signed words kept packed at the front of a
// register store. Commands: clear, push back, push front, pop back, pop
// front, insert at a position, erase at a position, and find first match.
// Every command beat yields exactly one result beat with a status (ok, full,
// empty, position out of range), the find outcome and the count afterward.
// A command passes three steps: capture, execute, and resolve into the output
// register. All entries shift or compare at once in the execute cycle, and the
// lowest matching index is encoded in the resolve cycle, which waits while the
// previous result is still held in the output register. A new command is
// taken while a finished result waits there. No clearing pass after reset.
module sequential_list_engine #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  sle_in_if.sink         in_ch,
  sle_out_if.source      out_ch
);
  import sle_pkg::*;

  sle_cmd_t   ctl;
  sle_stat_t  stat;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .ctl      (ctl),
    .stat     (stat)
  );

  sle_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_command      (in_ch.command),
    .in_position     (in_ch.position),
    .in_value        (in_ch.value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_found       (out_ch.found),
    .out_match_index (out_ch.match_index),
    .out_count       (out_ch.count)
  );

endmodule

// ===== tb/sequential_list_engine_tb.sv =====
module sequential_list_engine_tb;
  import sle_pkg::*;

  localparam int LIST_DEPTH = 16;

  // One expected result beat
  typedef struct {
    status_e_t            status;
    logic                 found;
    logic [INDEX_W-1:0]   match_index;
    logic [COUNT_W-1:0]   count;
  } list_result_t;

  // Shadow copy of the list; predicts and checks result beats in order
  class list_scoreboard;
    logic [VALUE_W-1:0] words [LIST_DEPTH];
    int unsigned        held;
    list_result_t       due_q[$];
    int                 errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Apply one accepted command beat and queue its result
    function void note_command(cmd_e_t cmd, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] value);
      list_result_t r;
      int unsigned  at;
      r.status      = ST_OK;
      r.found       = 1'b0;
      r.match_index = '0;
      case (cmd)
        CMD_CLEAR: held = 0;
        CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
          at = (cmd == CMD_PUSH_BACK) ? held : (cmd == CMD_PUSH_FRONT) ? 0 : pos;
          // range check wins over full
          if (at > held) r.status = ST_RANGE;
          else if (held >= LIST_DEPTH) r.status = ST_FULL;
          else begin
            for (int k = held; k > at; k--) words[k] = words[k-1];
            words[at] = value;
            held++;
          end
        end
        CMD_POP_BACK, CMD_POP_FRONT, CMD_ERASE: begin
          at = (cmd == CMD_POP_BACK) ? held - 1 : (cmd == CMD_POP_FRONT) ? 0 : pos;
          if (held == 0) r.status = ST_EMPTY;
          else if (at >= held) r.status = ST_RANGE;
          else begin
            for (int k = at; k + 1 < held; k++) words[k] = words[k+1];
            held--;
          end
        end
        default: begin
          // first match among live entries only
          for (int k = 0; k < held; k++) begin
            if (words[k] == value) begin
              r.found       = 1'b1;
              r.match_index = k[INDEX_W-1:0];
              break;
            end
          end
        end
      endcase
      r.count = held[COUNT_W-1:0];
      due_q.push_back(r);
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void check_result(status_e_t status, logic found, logic [INDEX_W-1:0] idx,
                               logic [COUNT_W-1:0] count);
      list_result_t e;
      if (due_q.size() == 0) begin
        report($sformatf("result beat with none pending: status=%0d found=%0b idx=%0d count=%0d",
                         status, found, idx, count));
        return;
      end
      e = due_q.pop_front();
      if (status !== e.status || found !== e.found || idx !== e.match_index ||
          count !== e.count)
        report($sformatf("exp status=%0d found=%0b idx=%0d count=%0d, got %0d %0b %0d %0d",
                         e.status, e.found, e.match_index, e.count,
                         status, found, idx, count));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic burst;

  sle_in_if  in_ch();
  sle_out_if out_ch();

  list_scoreboard sb = new();

  sequential_list_engine #(
    .DEPTH(LIST_DEPTH),
    .DATA_WIDTH(VALUE_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    #6000000;
    $display("sequential_list_engine_tb failed");
    $finish;
  end

  // Beat monitor: check results before noting the command of the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.status, out_ch.found, out_ch.match_index, out_ch.count);
      if (in_ch.valid && in_ch.ready)
        sb.note_command(in_ch.command, in_ch.position, in_ch.value);
    end
  end

  // Result side: random stall before each beat, none in burst phases
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Send one command beat after a random gap; returns at its accept edge
  task automatic issue_command(input cmd_e_t cmd, input logic [POS_W-1:0] pos,
                               input logic [VALUE_W-1:0] value);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.position <= pos;
    in_ch.value    <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold off until every queued result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Command mix per phase: 0 grows the list, 1 shrinks it, 2 balanced
  function automatic cmd_e_t pick_command(int mode);
    int w[8];
    int r;
    case (mode)
      0:       w = '{1, 25, 15, 8, 6, 20, 8, 17};
      1:       w = '{1, 8, 6, 22, 18, 8, 22, 15};
      default: w = '{3, 14, 12, 12, 12, 14, 14, 19};
    endcase
    r = $urandom_range(0, 99);
    for (int k = 0; k < 8; k++) begin
      if (r < w[k]) return cmd_e_t'(k);
      r -= w[k];
    end
    return CMD_FIND;
  endfunction

  // Mostly a small pool so finds hit duplicates; the rest fully random
  function automatic logic [VALUE_W-1:0] pick_value(cmd_e_t cmd);
    logic [VALUE_W-1:0] pool[8];
    pool = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h5,
             32'h0000_ffff, 32'haaaa_aaaa};
    if (cmd == CMD_FIND && sb.held > 0 && $urandom_range(0, 9) < 6)
      return sb.words[$urandom_range(0, sb.held - 1)];
    if ($urandom_range(0, 9) < 6) return pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, sb.held));
    return POS_W'($urandom_range(0, 31));
  endfunction

  // Stimulus
  initial begin
    cmd_e_t cmd;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_CLEAR;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    burst          <= 1'b0;
    rst_n          <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: pops, erase and find have nothing to work on; insert past the end
    issue_command(CMD_POP_BACK, 5'd0, 32'h0);
    issue_command(CMD_POP_FRONT, 5'd0, 32'h0);
    issue_command(CMD_ERASE, 5'd0, 32'h0);
    issue_command(CMD_FIND, 5'd0, 32'h0);
    issue_command(CMD_INSERT, 5'd1, 32'h1);
    // value extremes, insert at the end, bad positions
    issue_command(CMD_INSERT, 5'd0, 32'h8000_0000);
    issue_command(CMD_PUSH_BACK, 5'd0, 32'h7fff_ffff);
    issue_command(CMD_PUSH_FRONT, 5'd0, 32'hffff_ffff);
    issue_command(CMD_INSERT, 5'd3, 32'h0);
    issue_command(CMD_INSERT, 5'd31, 32'h2);
    issue_command(CMD_ERASE, 5'd4, 32'h0);
    issue_command(CMD_ERASE, 5'd31, 32'h0);
    issue_command(CMD_FIND, 5'd0, 32'h7fff_ffff);
    issue_command(CMD_FIND, 5'd0, 32'h0001_2345);
    // fill up to the last entry, last one distinct
    for (int k = 0; k < 11; k++)
      issue_command(cmd_e_t'((k % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK), 5'd0,
                    32'h5555_5555 ^ k);
    issue_command(CMD_PUSH_BACK, 5'd0, 32'h0f0f_0f0f);
    // full list
    issue_command(CMD_PUSH_BACK, 5'd0, 32'h3);
    issue_command(CMD_PUSH_FRONT, 5'd0, 32'h3);
    issue_command(CMD_INSERT, 5'd16, 32'h3);
    issue_command(CMD_INSERT, 5'd17, 32'h3);
    issue_command(CMD_FIND, 5'd0, 32'h0f0f_0f0f);
    issue_command(CMD_ERASE, 5'd15, 32'h0);
    issue_command(CMD_ERASE, 5'd0, 32'h0);
    issue_command(CMD_POP_BACK, 5'd0, 32'h0);
    issue_command(CMD_POP_FRONT, 5'd0, 32'h0);
    // clear keeps old words, but find must not see them
    issue_command(CMD_CLEAR, 5'd0, 32'h0);
    issue_command(CMD_FIND, 5'd0, 32'h7fff_ffff);
    issue_command(CMD_POP_FRONT, 5'd0, 32'h0);
    wait_drained();

    // random phases
    for (int phase = 0; phase < 20; phase++) begin
      burst <= ($urandom_range(0, 3) == 0);
      if (phase % 5 == 4) wait_drained();
      for (int n = 0; n < 60; n++) begin
        cmd = pick_command(phase % 3);
        issue_command(cmd, pick_position(), pick_value(cmd));
      end
    end

    // drain and settle
    in_ch.valid <= 1'b0;
    burst       <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sequential_list_engine_tb passed");
    end else begin
      $display("sequential_list_engine_tb failed");
    end
    $finish;
  end

endmodule
